// ----- rtl/ggev_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gate grid evaluator package
// Command and gate codes, source tags and the small control structs that the
// grid sequencer shares with its storage and its gate unit.
// ----------------------------------------------------------------------------
package ggev_pkg;

    // Commands carried in the input stream's tuser field.
    localparam logic [2:0] CMD_CLEAR       = 3'd0;
    localparam logic [2:0] CMD_SET_GATE    = 3'd1;
    localparam logic [2:0] CMD_CONNECT     = 3'd2;
    localparam logic [2:0] CMD_WRITE_INPUT = 3'd3;
    localparam logic [2:0] CMD_BIND        = 3'd4;
    localparam logic [2:0] CMD_EVALUATE    = 3'd5;

    // Gate kinds; the two remaining codes produce zero.
    localparam logic [2:0] GATE_NAND = 3'd0;
    localparam logic [2:0] GATE_NOR  = 3'd1;
    localparam logic [2:0] GATE_XNOR = 3'd2;
    localparam logic [2:0] GATE_AND  = 3'd3;
    localparam logic [2:0] GATE_OR   = 3'd4;
    localparam logic [2:0] GATE_XOR  = 3'd5;

    // Tag in the top two bits of a stored source.
    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_CELL = 2'd1;
    localparam logic [1:0] SRC_EXT  = 2'd2;

    localparam logic [1:0] SLOT_FIRST = 2'd1;

    localparam int         EXT_COUNT   = 16;
    localparam int         EXT_IDX_W   = 4;
    localparam int         MAX_REPORTS = 8;
    localparam logic [7:0] BYTE_ONE    = 8'h01;
    localparam logic [7:0] BYTE_FULL   = 8'hFF;

    // Write enables into the cell store.
    typedef struct packed {
        logic gate;
        logic src_a;
        logic src_b;
        logic value;
    } t_store_we;

    // How one gate operand is to be picked in the evaluation stage.
    typedef struct packed {
        logic [1:0] kind;
        logic       self_rd;
        logic       fwd;
    } t_opnd_ctl;

endpackage
`default_nettype wire

// ----- rtl/ggev_gate_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gate grid evaluator gate unit
// Selects both operands of the cell under evaluation and applies its gate.
// ----------------------------------------------------------------------------
module ggev_gate_unit
    import ggev_pkg::*;
(
    input  logic [2:0] i_gate,
    input  t_opnd_ctl  i_ctl_a,
    input  t_opnd_ctl  i_ctl_b,
    input  logic [7:0] i_cell_a,
    input  logic [7:0] i_cell_b,
    input  logic [7:0] i_ext_a,
    input  logic [7:0] i_ext_b,
    input  logic [7:0] i_fwd_val,
    output logic [7:0] o_result
);

    logic [7:0] w_a;
    logic [7:0] w_b;

    // An external byte is taken as read. A cell that reads itself sees zero,
    // and a cell written in the same cycle as the read is taken from the
    // forwarded result.
    function automatic logic [7:0] pick(input t_opnd_ctl c, input logic [7:0] cell_val,
                                        input logic [7:0] ext, input logic [7:0] fwd);
        logic [7:0] v;
        if (c.kind == SRC_EXT) begin
            v = ext;
        end else if (c.self_rd) begin
            v = 8'h00;
        end else if (c.fwd) begin
            v = fwd;
        end else begin
            v = cell_val;
        end
        return v;
    endfunction

    assign w_a = pick(i_ctl_a, i_cell_a, i_ext_a, i_fwd_val);
    assign w_b = pick(i_ctl_b, i_cell_b, i_ext_b, i_fwd_val);

    always_comb begin
        if (i_ctl_a.kind == SRC_NONE || i_ctl_b.kind == SRC_NONE) begin
            o_result = 8'h00;
        end else begin
            case (i_gate)
                GATE_NAND: o_result = ~(w_a & w_b);
                GATE_NOR:  o_result = ~(w_a | w_b);
                GATE_XNOR: o_result = ~(w_a ^ w_b);
                GATE_AND:  o_result = w_a & w_b;
                GATE_OR:   o_result = w_a | w_b;
                GATE_XOR:  o_result = w_a ^ w_b;
                default:   o_result = 8'h00;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ggev_cell_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gate grid evaluator cell store
// Per-cell gate kind, two sources and output byte, with registered reads.
// ----------------------------------------------------------------------------
module ggev_cell_store
    import ggev_pkg::*;
#(
    parameter int CELLS  = 64,
    parameter int ADDR_W = $clog2(CELLS),
    parameter int SRCW   = 8
) (
    input  logic              i_clk,
    input  t_store_we         i_we,
    input  logic [ADDR_W-1:0] i_attr_addr,
    input  logic [2:0]        i_gate,
    input  logic [SRCW-1:0]   i_src_a,
    input  logic [SRCW-1:0]   i_src_b,
    input  logic [ADDR_W-1:0] i_val_wr_addr,
    input  logic [7:0]        i_val_wr_data,
    input  logic [ADDR_W-1:0] i_attr_rd_addr,
    input  logic [ADDR_W-1:0] i_val_rd_addr_a,
    input  logic [ADDR_W-1:0] i_val_rd_addr_b,
    output logic [2:0]        o_gate,
    output logic [SRCW-1:0]   o_src_a,
    output logic [SRCW-1:0]   o_src_b,
    output logic [7:0]        o_val_a,
    output logic [7:0]        o_val_b
);

    logic [2:0]      r_gate_mem  [CELLS];
    logic [SRCW-1:0] r_src_a_mem [CELLS];
    logic [SRCW-1:0] r_src_b_mem [CELLS];
    logic [7:0]      r_val_mem   [CELLS];

    // Reads return the contents from before a write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_we.gate) begin
            r_gate_mem[i_attr_addr] <= i_gate;
        end
        o_gate <= r_gate_mem[i_attr_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.src_a) begin
            r_src_a_mem[i_attr_addr] <= i_src_a;
        end
        o_src_a <= r_src_a_mem[i_attr_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.src_b) begin
            r_src_b_mem[i_attr_addr] <= i_src_b;
        end
        o_src_b <= r_src_b_mem[i_attr_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.value) begin
            r_val_mem[i_val_wr_addr] <= i_val_wr_data;
        end
        o_val_a <= r_val_mem[i_val_rd_addr_a];
        o_val_b <= r_val_mem[i_val_rd_addr_b];
    end

endmodule
`default_nettype wire

// ----- rtl/gate_grid_evaluator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gate grid evaluator core
// A grid of two-input byte gates that is built up by commands and evaluated
// column by column, reporting one bit per output row of the last column.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Transfer when              Payload
//  s_axis     in         tvalid & tready            tuser: command
//                                                   tdata: cell, slot, gate, input byte
//  m_axis     out        tvalid & tready            tdata: out_index, out_bit
//                                                   tlast: final bit of a run
//  cfg        in         i_cfg_we                   register index and value
//
// Set gate, connect, write input and unknown commands are handled in idle
// without leaving it. Bind writes the bound row pairs one after another, and
// clear sweeps every cell of the store. Evaluate issues one cell per cycle
// through the shared gate unit, fed from the cell store's registered read
// ports, then drains the pipeline, then reads, loads and sends each reported
// bit in turn, holding while the output stalls. After reset the block sweeps
// the cell store and accepts no command meanwhile; input tready is high only
// while the block is idle.
// ----------------------------------------------------------------------------
module gate_grid_evaluator_core
    import ggev_pkg::*;
#(
    parameter int GRID_COLS = 8,
    parameter int GRID_ROWS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Fields from bit 0 up: src_col[2:0], src_row[5:3], dst_col[8:6],
    // dst_row[11:9], input_slot[13:12], gate_code[16:14], input_index[20:17],
    // input_byte[28:21], zero fill[31:29].
    input  logic [31:0] i_s_axis_tdata,
    // Fields from bit 0 up: command[2:0].
    input  logic [2:0]  i_s_axis_tuser,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Fields from bit 0 up: out_index[2:0], out_bit[3], zero fill[7:4].
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [4:0]  i_cfg_data
);

    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int CW    = $clog2(CELLS);
    localparam int COLW  = $clog2(GRID_COLS);
    localparam int ROWW  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CCNTW = $clog2(GRID_COLS + 1);
    localparam int RCNTW = $clog2(GRID_ROWS + 1);
    localparam int IW    = (CW > EXT_IDX_W) ? CW : EXT_IDX_W;
    localparam int SRCW  = 2 + IW;

    localparam logic [1:0] CFG_COLS    = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_INPUTS  = 2'd2;
    localparam logic [1:0] CFG_OUTPUTS = 2'd3;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_BIND  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_LOAD  = 3'd6;
    localparam logic [2:0] ST_SEND  = 3'd7;

    // Input fields.
    logic [2:0] w_command;
    logic [2:0] w_src_col;
    logic [2:0] w_src_row;
    logic [2:0] w_dst_col;
    logic [2:0] w_dst_row;
    logic [1:0] w_slot;
    logic [2:0] w_gate_code;
    logic [3:0] w_input_index;
    logic [7:0] w_input_byte;

    assign w_command     = i_s_axis_tuser;
    assign w_src_col     = i_s_axis_tdata[2:0];
    assign w_src_row     = i_s_axis_tdata[5:3];
    assign w_dst_col     = i_s_axis_tdata[8:6];
    assign w_dst_row     = i_s_axis_tdata[11:9];
    assign w_slot        = i_s_axis_tdata[13:12];
    assign w_gate_code   = i_s_axis_tdata[16:14];
    assign w_input_index = i_s_axis_tdata[20:17];
    assign w_input_byte  = i_s_axis_tdata[28:21];

    // Configuration registers.
    logic [3:0] r_cols_cfg;
    logic [3:0] r_rows_cfg;
    logic [4:0] r_inputs_cfg;
    logic [3:0] r_outputs_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg    <= 4'd8;
            r_rows_cfg    <= 4'd8;
            r_inputs_cfg  <= 5'd2;
            r_outputs_cfg <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_COLS:    r_cols_cfg    <= i_cfg_data[3:0];
                CFG_ROWS:    r_rows_cfg    <= i_cfg_data[3:0];
                CFG_INPUTS:  r_inputs_cfg  <= i_cfg_data;
                CFG_OUTPUTS: r_outputs_cfg <= i_cfg_data[3:0];
                default:     ;
            endcase
        end
    end

    // Effective grid size, bound pair count and report count. The register
    // values are saturated into the grid and the count of reports is clipped
    // to the rows in use and to eight.
    logic [CCNTW-1:0] w_eff_cols;
    logic [RCNTW-1:0] w_eff_rows;
    logic [3:0]       w_pairs;
    logic [3:0]       w_reports;

    always_comb begin
        if (r_cols_cfg == 4'd0) begin
            w_eff_cols = CCNTW'(1);
        end else if (int'(r_cols_cfg) > GRID_COLS) begin
            w_eff_cols = CCNTW'(GRID_COLS);
        end else begin
            w_eff_cols = CCNTW'(r_cols_cfg);
        end

        if (r_rows_cfg == 4'd0) begin
            w_eff_rows = RCNTW'(1);
        end else if (int'(r_rows_cfg) > GRID_ROWS) begin
            w_eff_rows = RCNTW'(GRID_ROWS);
        end else begin
            w_eff_rows = RCNTW'(r_rows_cfg);
        end

        w_pairs = r_inputs_cfg[4:1];
        if (int'(w_pairs) > EXT_COUNT / 2) begin
            w_pairs = 4'(EXT_COUNT / 2);
        end
        if (int'(w_pairs) > int'(w_eff_rows)) begin
            w_pairs = 4'(w_eff_rows);
        end

        w_reports = r_outputs_cfg;
        if (int'(w_reports) > int'(w_eff_rows)) begin
            w_reports = 4'(w_eff_rows);
        end
        if (int'(w_reports) > MAX_REPORTS) begin
            w_reports = 4'(MAX_REPORTS);
        end
    end

    // Sequencer state and counters.
    logic [2:0]      r_state;
    logic [2:0]      n_state;
    logic [CW-1:0]   r_idx;     // clear sweep and bind row
    logic [COLW-1:0] r_col;
    logic [ROWW-1:0] r_row;
    logic [CW-1:0]   r_base;    // first cell of the current column
    logic [2:0]      r_oidx;

    // Evaluation pipeline: stage one holds the cell's attributes coming out
    // of the store, stage two holds its operands and runs the gate unit.
    logic            r_v1;
    logic [CW-1:0]   r_k1;
    logic            r_v2;
    logic [CW-1:0]   r_k2;
    logic [2:0]      r_gate2;
    t_opnd_ctl       r_ctl_a2;
    t_opnd_ctl       r_ctl_b2;
    logic [7:0]      r_fwd_val;

    // Output register.
    logic            r_m_valid;
    logic [2:0]      r_out_index;
    logic            r_out_bit;
    logic            r_out_last;

    // External input bytes with per-entry valid bits so reset reads as zero.
    logic [7:0]           r_ext_mem [EXT_COUNT];
    logic [EXT_COUNT-1:0] r_ext_vld;
    logic [7:0]           r_ext_a;
    logic [7:0]           r_ext_b;

    logic w_accept;
    logic w_dst_ok;
    logic w_src_ok;
    logic [CW-1:0] w_dst_idx;
    logic [CW-1:0] w_src_idx;
    logic [CW-1:0] w_issue_k;
    logic w_last_row;
    logic w_last_col;
    logic w_sweep_last;
    logic w_bind_last;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_dst_ok  = (int'(w_dst_col) < GRID_COLS) && (int'(w_dst_row) < GRID_ROWS);
    assign w_src_ok  = (int'(w_src_col) < GRID_COLS) && (int'(w_src_row) < GRID_ROWS);
    assign w_dst_idx = CW'(int'(w_dst_col) * GRID_ROWS + int'(w_dst_row));
    assign w_src_idx = CW'(int'(w_src_col) * GRID_ROWS + int'(w_src_row));

    assign w_issue_k    = r_base + CW'(r_row);
    assign w_last_row   = (int'(r_row) + 1 == int'(w_eff_rows));
    assign w_last_col   = (int'(r_col) + 1 == int'(w_eff_cols));
    assign w_sweep_last = (int'(r_idx) == CELLS - 1);
    assign w_bind_last  = (int'(r_idx) + 1 == int'(w_pairs));

    // Store interface.
    t_store_we       w_we;
    logic [CW-1:0]   w_attr_addr;
    logic [2:0]      w_gate_wr;
    logic [SRCW-1:0] w_src_a_wr;
    logic [SRCW-1:0] w_src_b_wr;
    logic [CW-1:0]   w_val_wr_addr;
    logic [7:0]      w_val_wr_data;
    logic [CW-1:0]   w_val_rd_a;
    logic [2:0]      w_gate1;
    logic [SRCW-1:0] w_src_a1;
    logic [SRCW-1:0] w_src_b1;
    logic [7:0]      w_cell_a;
    logic [7:0]      w_cell_b;
    logic [7:0]      w_result;

    logic [1:0]    w_kind_a1;
    logic [1:0]    w_kind_b1;
    logic [CW-1:0] w_idx_a1;
    logic [CW-1:0] w_idx_b1;
    t_opnd_ctl     w_ctl_a1;
    t_opnd_ctl     w_ctl_b1;

    assign w_kind_a1 = w_src_a1[SRCW-1 -: 2];
    assign w_kind_b1 = w_src_b1[SRCW-1 -: 2];
    assign w_idx_a1  = w_src_a1[CW-1:0];
    assign w_idx_b1  = w_src_b1[CW-1:0];

    // A cell reading itself sees zero; a cell read while the stage-two cell
    // is being written takes the value leaving the gate unit.
    always_comb begin
        w_ctl_a1.kind    = w_kind_a1;
        w_ctl_a1.self_rd = (w_kind_a1 == SRC_CELL) && (w_idx_a1 == r_k1);
        w_ctl_a1.fwd     = (w_kind_a1 == SRC_CELL) && r_v2 && (w_idx_a1 == r_k2);
        w_ctl_b1.kind    = w_kind_b1;
        w_ctl_b1.self_rd = (w_kind_b1 == SRC_CELL) && (w_idx_b1 == r_k1);
        w_ctl_b1.fwd     = (w_kind_b1 == SRC_CELL) && r_v2 && (w_idx_b1 == r_k2);
    end

    // Store write steering: clear sweep, bind, command writes from idle and
    // the evaluation result.
    always_comb begin
        w_we          = '0;
        w_attr_addr   = w_dst_idx;
        w_gate_wr     = w_gate_code;
        w_src_a_wr    = {SRC_CELL, IW'(w_src_idx)};
        w_src_b_wr    = {SRC_CELL, IW'(w_src_idx)};
        w_val_wr_addr = r_k2;
        w_val_wr_data = w_result;
        w_we.value    = r_v2;

        case (r_state)
            ST_CLEAR: begin
                w_we          = '1;
                w_attr_addr   = r_idx;
                w_gate_wr     = GATE_NAND;
                w_src_a_wr    = {SRC_NONE, IW'(0)};
                w_src_b_wr    = {SRC_NONE, IW'(0)};
                w_val_wr_addr = r_idx;
                w_val_wr_data = 8'h00;
            end
            ST_BIND: begin
                w_we.src_a  = 1'b1;
                w_we.src_b  = 1'b1;
                w_attr_addr = r_idx;
                w_src_a_wr  = {SRC_EXT, IW'(2 * int'(r_idx))};
                w_src_b_wr  = {SRC_EXT, IW'(2 * int'(r_idx) + 1)};
            end
            ST_IDLE: begin
                if (w_accept && w_command == CMD_SET_GATE) begin
                    w_we.gate = w_dst_ok;
                end
                if (w_accept && w_command == CMD_CONNECT && w_dst_ok && w_src_ok) begin
                    w_we.src_a = (w_slot == SLOT_FIRST);
                    w_we.src_b = (w_slot != SLOT_FIRST);
                end
            end
            default: ;
        endcase
    end

    // Port A also serves the reporting reads of the last column in use.
    assign w_val_rd_a = (r_state == ST_READ) ? (r_base + CW'(r_oidx)) : w_idx_a1;

    ggev_cell_store #(
        .CELLS  (CELLS),
        .ADDR_W (CW),
        .SRCW   (SRCW)
    ) u_store (
        .i_clk           (i_clk),
        .i_we            (w_we),
        .i_attr_addr     (w_attr_addr),
        .i_gate          (w_gate_wr),
        .i_src_a         (w_src_a_wr),
        .i_src_b         (w_src_b_wr),
        .i_val_wr_addr   (w_val_wr_addr),
        .i_val_wr_data   (w_val_wr_data),
        .i_attr_rd_addr  (w_issue_k),
        .i_val_rd_addr_a (w_val_rd_a),
        .i_val_rd_addr_b (w_idx_b1),
        .o_gate          (w_gate1),
        .o_src_a         (w_src_a1),
        .o_src_b         (w_src_b1),
        .o_val_a         (w_cell_a),
        .o_val_b         (w_cell_b)
    );

    ggev_gate_unit u_gate (
        .i_gate    (r_gate2),
        .i_ctl_a   (r_ctl_a2),
        .i_ctl_b   (r_ctl_b2),
        .i_cell_a  (w_cell_a),
        .i_cell_b  (w_cell_b),
        .i_ext_a   (r_ext_a),
        .i_ext_b   (r_ext_b),
        .i_fwd_val (r_fwd_val),
        .o_result  (w_result)
    );

    // External bytes: written from idle, read by stage one for stage two.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_command == CMD_WRITE_INPUT) begin
            r_ext_mem[w_input_index] <= (w_input_byte == BYTE_ONE) ? BYTE_FULL : w_input_byte;
        end
        r_ext_a <= r_ext_vld[w_src_a1[EXT_IDX_W-1:0]] ?
                   r_ext_mem[w_src_a1[EXT_IDX_W-1:0]] : 8'h00;
        r_ext_b <= r_ext_vld[w_src_b1[EXT_IDX_W-1:0]] ?
                   r_ext_mem[w_src_b1[EXT_IDX_W-1:0]] : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_vld <= '0;
        end else if (w_accept && w_command == CMD_WRITE_INPUT) begin
            r_ext_vld[w_input_index] <= 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (w_sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_command)
                        CMD_CLEAR:    n_state = ST_CLEAR;
                        CMD_BIND:     n_state = (w_pairs != 4'd0) ? ST_BIND : ST_IDLE;
                        CMD_EVALUATE: n_state = ST_EVAL;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_BIND: begin
                if (w_bind_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EVAL: begin
                if (w_last_row && w_last_col) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = (w_reports == 4'd0) ? ST_IDLE : ST_READ;
                end
            end
            ST_READ:  n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_SEND;
            ST_SEND: begin
                if (i_m_axis_tready) begin
                    n_state = r_out_last ? ST_IDLE : ST_READ;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_idx     <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_m_valid <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
            r_base    <= '0;
            r_oidx    <= '0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == ST_EVAL);
            r_v2    <= r_v1;

            case (r_state)
                ST_CLEAR, ST_BIND: begin
                    r_idx <= r_idx + CW'(1);
                end
                ST_IDLE: begin
                    r_idx  <= '0;
                    r_col  <= '0;
                    r_row  <= '0;
                    r_base <= '0;
                    r_oidx <= '0;
                end
                ST_EVAL: begin
                    // The last column's base is kept for the reporting reads.
                    if (!w_last_row) begin
                        r_row <= r_row + ROWW'(1);
                    end else if (!w_last_col) begin
                        r_row  <= '0;
                        r_col  <= r_col + COLW'(1);
                        r_base <= r_base + CW'(GRID_ROWS);
                    end
                end
                ST_LOAD: begin
                    r_m_valid <= 1'b1;
                end
                ST_SEND: begin
                    if (i_m_axis_tready) begin
                        r_m_valid <= 1'b0;
                        r_oidx    <= r_oidx + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Pipeline and output payload.
    always_ff @(posedge i_clk) begin
        r_k1      <= w_issue_k;
        r_k2      <= r_k1;
        r_gate2   <= w_gate1;
        r_ctl_a2  <= w_ctl_a1;
        r_ctl_b2  <= w_ctl_b1;
        r_fwd_val <= w_result;
        if (r_state == ST_LOAD) begin
            r_out_index <= r_oidx;
            r_out_bit   <= (w_cell_a == BYTE_FULL);
            r_out_last  <= (int'(r_oidx) + 1 == int'(w_reports));
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_bit, r_out_index};
    assign o_m_axis_tlast  = r_out_last;

    // No command is taken while cells are in flight or a bit is on offer.
    a_idle_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (!o_m_axis_tvalid && !r_v1 && !r_v2))
        else $error("command accepted while evaluation or reporting is active");

    // The final bit of a run returns the block to idle.
    a_last_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=> o_s_axis_tready)
        else $error("block not idle after the final report transfer");

    // A gate evaluation only follows an attribute read in the previous cycle.
    a_pipe_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> ($past(r_v1) && (r_state == ST_EVAL || r_state == ST_DRAIN)))
        else $error("evaluation stage active without its attribute read");

endmodule
`default_nettype wire

// ----- tb/sv/gate_grid_evaluator_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gate grid evaluator core testbench
// Builds small gate circuits through the command stream, evaluates them and
// checks every reported output bit against a cycle-free model of the grid.
// Register settings and flow-control pressure change between phases.
// ----------------------------------------------------------------------------
module gate_grid_evaluator_core_tb;
    import ggev_pkg::*;

    localparam int GRID_COLS = 8;
    localparam int GRID_ROWS = 8;
    localparam int CELLS     = GRID_COLS * GRID_ROWS;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_COLS    = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_INPUTS  = 2'd2;
    localparam logic [1:0] REG_OUTPUTS = 2'd3;

    // Codes that the block must tolerate but that carry no function, and slot codes other than the first.
    localparam logic [2:0] CMD_SPARE6  = 3'd6;
    localparam logic [2:0] CMD_SPARE7  = 3'd7;
    localparam logic [2:0] GATE_UNUSED = 3'd7;
    localparam logic [1:0] SLOT_SECOND = 2'd2;
    localparam logic [1:0] SLOT_ZERO   = 2'd0;
    localparam logic [1:0] SLOT_THREE  = 2'd3;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 47;
    // Longest quiet stretch of the block: a clear, or an evaluate plus its fill.
    localparam int DRAIN_CYCLES  = 100;
    localparam int LIMIT_CYCLES  = 600000;

    // Input tdata layout, most significant field first; src_col sits at bit 0.
    typedef struct packed {
        logic [2:0] fill;
        logic [7:0] in_byte;
        logic [3:0] in_idx;
        logic [2:0] gate;
        logic [1:0] slot;
        logic [2:0] dst_row;
        logic [2:0] dst_col;
        logic [2:0] src_row;
        logic [2:0] src_col;
    } t_cmd_fields;

    typedef struct packed {
        logic [2:0]  cmd;
        t_cmd_fields f;
    } t_cmd_item;

    // One reported bit of the last column.
    typedef struct packed {
        logic [2:0] row;
        logic       hit;
        logic       last;
    } t_row_report;

    // A gate operand: nothing, a cell output or an external byte.
    typedef struct packed {
        logic [1:0] tag;
        logic [5:0] idx;
    } t_src_ref;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [31:0] i_s_axis_tdata = '0;
    logic [2:0]  i_s_axis_tuser = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [4:0]  i_cfg_data = '0;

    gate_grid_evaluator_core #(
        .GRID_COLS(GRID_COLS),
        .GRID_ROWS(GRID_ROWS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Grid model. Cell k holds column k / GRID_ROWS, row k % GRID_ROWS.
    // ------------------------------------------------------------------------
    logic [2:0] mdl_gate  [CELLS];
    t_src_ref   mdl_src_a [CELLS];
    t_src_ref   mdl_src_b [CELLS];
    logic [7:0] mdl_val   [CELLS];
    logic [7:0] mdl_ext   [EXT_COUNT];
    logic [3:0] cfg_cols    = 4'd8;
    logic [3:0] cfg_rows    = 4'd8;
    logic [4:0] cfg_inputs  = 5'd2;
    logic [3:0] cfg_outputs = 4'd1;

    t_cmd_item   cmd_backlog[$];
    t_row_report expected_reports[$];

    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int          error_count    = 0;
    int          cycle_count    = 0;
    logic        in_taken       = 1'b0;
    t_cmd_item   next_cmd;

    // Column and row counts are saturated into 1..limit.
    function automatic int fit_span(input int value, input int limit);
        if (value < 1)
            return 1;
        if (value > limit)
            return limit;
        return value;
    endfunction

    function automatic logic [7:0] source_byte(input t_src_ref s);
        case (s.tag)
            SRC_EXT:  return mdl_ext[s.idx[3:0]];
            SRC_CELL: return mdl_val[s.idx];
            default:  return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] gate_out(input logic [2:0] kind,
                                            input logic [7:0] a, input logic [7:0] b);
        case (kind)
            GATE_NAND: return ~(a & b);
            GATE_NOR:  return ~(a | b);
            GATE_XNOR: return ~(a ^ b);
            GATE_AND:  return a & b;
            GATE_OR:   return a | b;
            GATE_XOR:  return a ^ b;
            default:   return 8'h00;
        endcase
    endfunction

    task automatic clear_grid_model();
        for (int k = 0; k < CELLS; k++) begin
            mdl_gate[k]  = GATE_NAND;
            mdl_src_a[k] = '{tag: SRC_NONE, idx: '0};
            mdl_src_b[k] = '{tag: SRC_NONE, idx: '0};
            mdl_val[k]   = 8'h00;
        end
    endtask

    // Applies one accepted command to the model and queues the bits that an
    // evaluate reports.
    task automatic apply_grid_command(input logic [2:0] cmd, input t_cmd_fields f);
        int ncols;
        int nrows;
        int pairs;
        int nrep;
        int dst;
        int k;
        int base;
        logic [7:0] a;
        logic [7:0] b;
        t_row_report rep;
        t_src_ref s;
        ncols = fit_span(int'(cfg_cols), GRID_COLS);
        nrows = fit_span(int'(cfg_rows), GRID_ROWS);
        dst   = int'(f.dst_col) * GRID_ROWS + int'(f.dst_row);
        case (cmd)
            CMD_CLEAR: clear_grid_model();
            CMD_SET_GATE: begin
                if (f.dst_col < GRID_COLS && f.dst_row < GRID_ROWS)
                    mdl_gate[dst] = f.gate;
            end
            CMD_CONNECT: begin
                if (f.dst_col < GRID_COLS && f.dst_row < GRID_ROWS &&
                    f.src_col < GRID_COLS && f.src_row < GRID_ROWS) begin
                    s.tag = SRC_CELL;
                    s.idx = 6'(int'(f.src_col) * GRID_ROWS + int'(f.src_row));
                    if (f.slot == SLOT_FIRST)
                        mdl_src_a[dst] = s;
                    else
                        mdl_src_b[dst] = s;
                end
            end
            CMD_WRITE_INPUT: begin
                mdl_ext[f.in_idx] = (f.in_byte == BYTE_ONE) ? BYTE_FULL : f.in_byte;
            end
            CMD_BIND: begin
                pairs = int'(cfg_inputs) / 2;
                if (pairs > EXT_COUNT / 2)
                    pairs = EXT_COUNT / 2;
                if (pairs > nrows)
                    pairs = nrows;
                for (int r = 0; r < pairs; r++) begin
                    mdl_src_a[r] = '{tag: SRC_EXT, idx: 6'(2 * r)};
                    mdl_src_b[r] = '{tag: SRC_EXT, idx: 6'(2 * r + 1)};
                end
            end
            CMD_EVALUATE: begin
                // Evaluation is in place: each cell is zeroed before its
                // sources are read, so a cell fed by itself reads zero and a
                // cell fed from later in the order reads the previous value.
                for (int c = 0; c < ncols; c++) begin
                    for (int r = 0; r < nrows; r++) begin
                        k = c * GRID_ROWS + r;
                        mdl_val[k] = 8'h00;
                        if (mdl_src_a[k].tag != SRC_NONE && mdl_src_b[k].tag != SRC_NONE) begin
                            a = source_byte(mdl_src_a[k]);
                            b = source_byte(mdl_src_b[k]);
                            mdl_val[k] = gate_out(mdl_gate[k], a, b);
                        end
                    end
                end
                nrep = int'(cfg_outputs);
                if (nrep > nrows)
                    nrep = nrows;
                if (nrep > MAX_REPORTS)
                    nrep = MAX_REPORTS;
                base = (ncols - 1) * GRID_ROWS;
                for (int r = 0; r < nrep; r++) begin
                    rep.row  = 3'(r);
                    rep.hit  = (mdl_val[base + r] == BYTE_FULL);
                    rep.last = (r + 1 == nrep);
                    expected_reports.push_back(rep);
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------------
    function automatic t_cmd_item make_cmd(input logic [2:0] cmd,
                                           input int scol, input int srow,
                                           input int dcol, input int drow,
                                           input logic [1:0] slot, input logic [2:0] gate,
                                           input int idx, input logic [7:0] value);
        t_cmd_item it;
        it.cmd       = cmd;
        it.f.fill    = '0;
        it.f.src_col = 3'(scol);
        it.f.src_row = 3'(srow);
        it.f.dst_col = 3'(dcol);
        it.f.dst_row = 3'(drow);
        it.f.slot    = slot;
        it.f.gate    = gate;
        it.f.in_idx  = 4'(idx);
        it.f.in_byte = value;
        return it;
    endfunction

    // Mostly commands that build a working circuit inside the evaluated area:
    // connections from the previous column, gates, input bytes mostly of 0x00,
    // 0x01 and 0xff. The remainder is bind, evaluate, clear, spare codes and noise.
    function automatic t_cmd_item random_cmd(input int ncols, input int nrows);
        t_cmd_item it;
        int pick;
        it.f      = t_cmd_fields'($urandom());
        it.f.fill = '0;
        pick      = $urandom_range(99);
        if (pick < 28) begin
            it.cmd       = CMD_CONNECT;
            it.f.dst_col = 3'($urandom_range(ncols - 1, (ncols > 1) ? 1 : 0));
            it.f.dst_row = 3'($urandom_range(nrows - 1, 0));
            if ($urandom_range(3) != 0) begin
                it.f.src_col = (it.f.dst_col == 0) ? 3'd0 : it.f.dst_col - 3'd1;
                it.f.src_row = 3'($urandom_range(nrows - 1, 0));
            end
            if ($urandom_range(7) != 0)
                it.f.slot = 2'($urandom_range(2, 1));
        end else if (pick < 43) begin
            it.cmd = CMD_SET_GATE;
            if ($urandom_range(7) != 0) begin
                it.f.dst_col = 3'($urandom_range(ncols - 1, 0));
                it.f.dst_row = 3'($urandom_range(nrows - 1, 0));
            end
        end else if (pick < 58) begin
            it.cmd = CMD_WRITE_INPUT;
            case ($urandom_range(3))
                0:       it.f.in_byte = 8'h00;
                1:       it.f.in_byte = BYTE_ONE;
                2:       it.f.in_byte = BYTE_FULL;
                default: ;
            endcase
        end else if (pick < 66) begin
            it.cmd = CMD_BIND;
        end else if (pick < 84) begin
            it.cmd = CMD_EVALUATE;
        end else if (pick < 87) begin
            it.cmd = CMD_CLEAR;
        end else if (pick < 91) begin
            it.cmd = $urandom_range(1) ? CMD_SPARE6 : CMD_SPARE7;
        end else begin
            it.cmd = 3'($urandom_range(7, 0));
        end
        return it;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Waits until every command is in, every bit is out, and the block has had
    // time to finish work that reports nothing, then for the input to open.
    task automatic wait_until_idle();
        do
            @(posedge i_clk);
        while (cmd_backlog.size() != 0 || i_s_axis_tvalid || expected_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Command driver: presents the next queued command at the falling edge
    // once the previous one has transferred, leaving gaps at random.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_axis_tvalid || in_taken)) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                next_cmd = cmd_backlog.pop_front();
                i_s_axis_tuser  <= next_cmd.cmd;
                i_s_axis_tdata  <= next_cmd.f;
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure.
    always @(negedge i_clk) begin
        i_m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: register writes and accepted commands update the model; each
    // output transfer is checked against the oldest expected bit.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_row_report want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_COLS:    cfg_cols    = i_cfg_data[3:0];
                    REG_ROWS:    cfg_rows    = i_cfg_data[3:0];
                    REG_INPUTS:  cfg_inputs  = i_cfg_data;
                    REG_OUTPUTS: cfg_outputs = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                apply_grid_command(i_s_axis_tuser, t_cmd_fields'(i_s_axis_tdata));
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected output transfer: row=%0d bit=%0d last=%0d",
                             $time, o_m_axis_tdata[2:0], o_m_axis_tdata[3], o_m_axis_tlast);
                    error_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (o_m_axis_tdata[2:0] !== want.row || o_m_axis_tdata[3] !== want.hit ||
                        o_m_axis_tlast !== want.last) begin
                        $display("%0t: output mismatch: expected row=%0d bit=%0d last=%0d, got row=%0d bit=%0d last=%0d",
                                 $time, want.row, want.hit, want.last,
                                 o_m_axis_tdata[2:0], o_m_axis_tdata[3], o_m_axis_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        int counted;
        int ncols;
        int nrows;
        logic [4:0] set_cols;
        logic [4:0] set_rows;
        logic [4:0] set_inputs;
        logic [4:0] set_outputs;
        t_cmd_item it;

        clear_grid_model();
        for (int i = 0; i < EXT_COUNT; i++)
            mdl_ext[i] = 8'h00;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // The block sweeps its cell store before it takes the first command.
        wait_until_idle();

        // Directed part: a two-column circuit that exercises every gate path and
        // whose last column has self feedback, a read of a not yet visited cell and
        // odd slot codes, then a later input write, spare codes and clear.
        write_reg(REG_COLS, 5'd2);
        write_reg(REG_ROWS, 5'd8);
        write_reg(REG_INPUTS, 5'd16);
        write_reg(REG_OUTPUTS, 5'd8);
        cmd_backlog.push_back(make_cmd(CMD_WRITE_INPUT, 0, 0, 0, 0, SLOT_ZERO, GATE_NAND, 0, BYTE_ONE));
        cmd_backlog.push_back(make_cmd(CMD_WRITE_INPUT, 0, 0, 0, 0, SLOT_ZERO, GATE_NAND, 1, BYTE_FULL));
        cmd_backlog.push_back(make_cmd(CMD_WRITE_INPUT, 0, 0, 0, 0, SLOT_ZERO, GATE_NAND, 2, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_WRITE_INPUT, 0, 0, 0, 0, SLOT_ZERO, GATE_NAND, 15, 8'h5a));
        cmd_backlog.push_back(make_cmd(CMD_BIND, 0, 0, 0, 0, SLOT_ZERO, GATE_NAND, 0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_SET_GATE, 0, 0, 0, 0, SLOT_ZERO, GATE_AND, 0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_SET_GATE, 0, 0, 0, 1, SLOT_ZERO, GATE_NAND, 0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_SET_GATE, 0, 0, 0, 2, SLOT_ZERO, GATE_NOR, 0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_SET_GATE, 0, 0, 0, 3, SLOT_ZERO, GATE_XOR, 0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_SET_GATE, 0, 0, 0, 4, SLOT_ZERO, GATE_UNUSED, 0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_CONNECT, 0, 0, 1, 0, SLOT_FIRST, GATE_NAND, 0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_CONNECT, 0, 1, 1, 0, SLOT_SECOND, GATE_NAND, 0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_SET_GATE, 0, 0, 1, 0, SLOT_ZERO, GATE_XNOR, 0, 8'h00));
        // Row 1 feeds itself and keeps the default NAND.
        cmd_backlog.push_back(make_cmd(CMD_CONNECT, 1, 1, 1, 1, SLOT_FIRST, GATE_NAND, 0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_CONNECT, 0, 2, 1, 1, SLOT_THREE, GATE_NAND, 0, 8'h00));
        // Row 2 reads row 3 of its own column before that cell is visited.
        cmd_backlog.push_back(make_cmd(CMD_CONNECT, 1, 3, 1, 2, SLOT_FIRST, GATE_NAND, 0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_CONNECT, 0, 1, 1, 2, SLOT_ZERO, GATE_NAND, 0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_SET_GATE, 0, 0, 1, 2, SLOT_ZERO, GATE_OR, 0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_EVALUATE, 0, 0, 0, 0, SLOT_ZERO, GATE_NAND, 0, 8'h00));
        // Bound inputs are held by reference, so this write shows up.
        cmd_backlog.push_back(make_cmd(CMD_WRITE_INPUT, 0, 0, 0, 0, SLOT_ZERO, GATE_NAND, 0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_EVALUATE, 0, 0, 0, 0, SLOT_ZERO, GATE_NAND, 0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_SPARE6, 7, 7, 7, 7, SLOT_THREE, GATE_UNUSED, 15, 8'hff));
        cmd_backlog.push_back(make_cmd(CMD_SPARE7, 7, 7, 7, 7, SLOT_THREE, GATE_UNUSED, 15, 8'hff));
        cmd_backlog.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, SLOT_ZERO, GATE_NAND, 0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_EVALUATE, 0, 0, 0, 0, SLOT_ZERO, GATE_NAND, 0, 8'h00));

        // Random phases. Each one writes every register and sets the pressure on
        // both sides; the first settings are the extremes of the registers.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_until_idle();
            case (ph)
                0: begin
                    set_cols = 5'd8; set_rows = 5'd8; set_inputs = 5'd16; set_outputs = 5'd8;
                end
                1: begin
                    set_cols = 5'd0; set_rows = 5'd0; set_inputs = 5'd0; set_outputs = 5'd0;
                end
                2: begin
                    set_cols = 5'd31; set_rows = 5'd31; set_inputs = 5'd31; set_outputs = 5'd31;
                end
                3: begin
                    set_cols = 5'd1; set_rows = 5'd8; set_inputs = 5'd2; set_outputs = 5'd8;
                end
                4: begin
                    set_cols = 5'd8; set_rows = 5'd1; set_inputs = 5'd16; set_outputs = 5'd1;
                end
                7: begin
                    set_cols    = 5'($urandom_range(31, 0));
                    set_rows    = 5'($urandom_range(31, 0));
                    set_inputs  = 5'($urandom_range(31, 0));
                    set_outputs = 5'($urandom_range(31, 0));
                end
                default: begin
                    set_cols    = 5'($urandom_range(8, 1));
                    set_rows    = 5'($urandom_range(8, 1));
                    set_inputs  = 5'($urandom_range(16, 0));
                    set_outputs = 5'($urandom_range(8, 1));
                end
            endcase
            write_reg(REG_COLS, set_cols);
            write_reg(REG_ROWS, set_rows);
            write_reg(REG_INPUTS, set_inputs);
            write_reg(REG_OUTPUTS, set_outputs);

            case (ph % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 47; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 47; end
                default: begin send_gap_pct = 24; recv_stall_pct = 24; end
            endcase

            // The model registers are current here; spare commands do not
            // count toward the phase length.
            ncols   = fit_span(int'(cfg_cols), GRID_COLS);
            nrows   = fit_span(int'(cfg_rows), GRID_ROWS);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                it = random_cmd(ncols, nrows);
                cmd_backlog.push_back(it);
                if (it.cmd <= CMD_EVALUATE)
                    counted++;
            end
        end

        wait_until_idle();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ggev_pkg.sv
rtl/ggev_gate_unit.sv
rtl/ggev_cell_store.sv
rtl/gate_grid_evaluator_core.sv
tb/sv/gate_grid_evaluator_core_tb.sv
